// ===== rtl/sirs_pkg.sv =====
package sirs_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int CFG_BITS  = 31;
	localparam int NUM_REGS  = 4;
	localparam int NUM_TERMS = 6;
	localparam int IDX_BITS  = 3;
	localparam int IN_FIELDS = 10;
	localparam int ADDR_BITS = 4;
	localparam int APB_BITS  = 32;

	// divider: numerator and quotient width, divisor width, step counter
	localparam int NUM_BITS  = 2 * WORD_BITS + 2;
	localparam int DEN_BITS  = 2 * WORD_BITS;
	localparam int CNT_BITS  = $clog2(NUM_BITS + 1);
	// products, accumulators
	localparam int PROD_BITS = 2 * WORD_BITS + 1;
	localparam int ACC_BITS  = 2 * WORD_BITS + 4;
	localparam int DSUM_BITS = 2 * WORD_BITS + 3;
	localparam int DIFF_BITS = WORD_BITS + 1;

	localparam int IN_DATA_BITS  = IN_FIELDS * WORD_BITS;
	localparam int OUT_DATA_BITS = 7 * WORD_BITS;

	// register indexes
	localparam logic [1:0] REG_MASS_A    = 2'd0;
	localparam logic [1:0] REG_MASS_B    = 2'd1;
	localparam logic [1:0] REG_INERTIA_A = 2'd2;
	localparam logic [1:0] REG_INERTIA_B = 2'd3;

	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(65536);

	// input field places in tdata
	localparam int F_BIAS = 6;
	localparam int F_LOW  = 7;
	localparam int F_HIGH = 8;
	localparam int F_IMP  = 9;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	// datapath operations
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_CAPTURE = 4'd1;
	localparam logic [3:0] OP_MUL_SQ  = 4'd2;
	localparam logic [3:0] OP_DIV_SQ  = 4'd3;
	localparam logic [3:0] OP_SUM_SQ  = 4'd4;
	localparam logic [3:0] OP_MUL_DOT = 4'd5;
	localparam logic [3:0] OP_ADD_DOT = 4'd6;
	localparam logic [3:0] OP_DIV_DL  = 4'd7;
	localparam logic [3:0] OP_DL      = 4'd8;
	localparam logic [3:0] OP_CLAMP   = 4'd9;
	localparam logic [3:0] OP_MUL_APP = 4'd10;
	localparam logic [3:0] OP_DIV_APP = 4'd11;
	localparam logic [3:0] OP_VEL     = 4'd12;
	localparam logic [3:0] OP_OUT     = 4'd13;

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_TERMS - 1);

	typedef logic [NUM_REGS-1:0][CFG_BITS-1:0] cfg_regs_t;

	typedef struct packed {
		logic [3:0]          op;
		logic [IDX_BITS-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic denom_zero;
		logic out_free;
		logic in_solve;
	} status_t;

	// which register divides term idx (A: x, y, w then B: x, y, w)
	function automatic logic [1:0] cfg_sel(input logic [IDX_BITS-1:0] idx);
		logic [1:0] r;
		case (idx) inside
			3'd0, 3'd1: r = REG_MASS_A;
			3'd2:       r = REG_INERTIA_A;
			3'd3, 3'd4: r = REG_MASS_B;
			default:    r = REG_INERTIA_B;
		endcase
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] abs_w(input logic [WORD_BITS-1:0] x);
		return x[WORD_BITS-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [DIFF_BITS-1:0] abs_d(input logic [DIFF_BITS-1:0] x);
		return x[DIFF_BITS-1] ? (~x + 1'b1) : x;
	endfunction

	// saturate a wide signed value to the word range
	function automatic logic [WORD_BITS-1:0] sat_w(input logic [ACC_BITS-1:0] x);
		logic signed [ACC_BITS-1:0] v;
		logic signed [ACC_BITS-1:0] mx;
		logic signed [ACC_BITS-1:0] mn;
		v  = $signed(x);
		mx = $signed({{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
		mn = -mx - 1;
		if (v > mx) return mx[WORD_BITS-1:0];
		if (v < mn) return mn[WORD_BITS-1:0];
		return x[WORD_BITS-1:0];
	endfunction

endpackage

// ===== rtl/sequential_impulse_row_solver.sv =====
// channel  | dir | ports                      | content
// s_       | in  | tvalid tready tdata tuser   | one request: load or solve
// m_       | out | tvalid tready tdata tuser   | impulse and both velocity sets
// apb      | in  | psel penable pwrite paddr.. | masses and inertias at 0,4,8,12
//
// A solve runs thirteen divisions (six denominator terms, the impulse change, six
// velocity increments) one quotient bit a cycle through the single shared divider,
// 66 steps each; a zero denominator skips the impulse division.
// Reset clears the velocities to zero and the registers to 1.0.
// A finished result waits in the output register while the next request is taken.
module sequential_impulse_row_solver (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// first_x, first_y, first_w, second_x, second_y, second_w, bias,
	// impulse_low, impulse_high, impulse_in
	input  logic [sirs_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// command, body_select
	input  logic [1:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// impulse_out, vel_a_x, vel_a_y, spin_a, vel_b_x, vel_b_y, spin_b
	output logic [sirs_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// denom_zero
	output logic                                 m_tuser,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sirs_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [sirs_pkg::APB_BITS-1:0]        pwdata,
	output logic [sirs_pkg::APB_BITS-1:0]        prdata,
	output logic                                 pready
);

	sirs_pkg::cfg_regs_t cfg_q;
	sirs_pkg::cmd_t      cmd;
	sirs_pkg::status_t   status;
	logic [1:0]          reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign prdata  = {1'b0, cfg_q[reg_idx]};

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < sirs_pkg::NUM_REGS; r++) cfg_q[r] <= sirs_pkg::CFG_RESET;
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[reg_idx] <= pwdata[sirs_pkg::CFG_BITS-1:0];
		end
	end

	sirs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sirs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.status    (status)
	);

endmodule

// ===== rtl/sirs_div.sv =====
module sirs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sirs_pkg::NUM_BITS-1:0] num,
	input  logic [sirs_pkg::DEN_BITS-1:0] den,
	output logic                         done,
	output logic [sirs_pkg::NUM_BITS-1:0] quot
);

	logic                          busy_q;
	logic                          done_q;
	logic [sirs_pkg::CNT_BITS-1:0] cnt_q;
	logic [sirs_pkg::NUM_BITS-1:0] num_q;
	logic [sirs_pkg::DEN_BITS-1:0] den_q;
	logic [sirs_pkg::DEN_BITS-1:0] rem_q;
	logic [sirs_pkg::DEN_BITS:0]   trial;
	logic                          ge;

	// one restoring step: shift in the next numerator bit, try the subtract
	always_comb begin
		trial = {rem_q, num_q[sirs_pkg::NUM_BITS-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sirs_pkg::CNT_BITS'(sirs_pkg::NUM_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? sirs_pkg::DEN_BITS'(trial - {1'b0, den_q})
			            : trial[sirs_pkg::DEN_BITS-1:0];
			num_q <= {num_q[sirs_pkg::NUM_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== rtl/sirs_datapath.sv =====
module sirs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sirs_pkg::cmd_t                      cmd,
	input  sirs_pkg::cfg_regs_t                 cfg,
	input  logic [sirs_pkg::IN_DATA_BITS-1:0]   in_data,
	input  logic [1:0]                          in_user,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [sirs_pkg::OUT_DATA_BITS-1:0]  out_data,
	output logic                                out_user,
	output sirs_pkg::status_t                   status
);

	localparam int W = sirs_pkg::WORD_BITS;

	logic [W-1:0] j_q [sirs_pkg::NUM_TERMS];
	logic [W-1:0] v_q [sirs_pkg::NUM_TERMS];
	logic [W-1:0] lo_q, hi_q, l0_q, imp_q;
	logic         flag_q;
	logic [sirs_pkg::ACC_BITS-1:0]  acc_q;
	logic [sirs_pkg::ACC_BITS-1:0]  dl_q;
	logic [sirs_pkg::DSUM_BITS-1:0] dsum_q;
	logic [sirs_pkg::DIFF_BITS-1:0] dfin_q;
	logic                           prod_neg_q;
	logic [sirs_pkg::PROD_BITS-1:0] prod_mag_q;

	logic                           out_valid_q;
	logic [W-1:0]                   out_word_q [7];
	logic                           out_flag_q;

	logic [sirs_pkg::IDX_BITS-1:0]  idx;
	logic [W-1:0]                   jk, vk;
	logic [sirs_pkg::DEN_BITS-1:0]  mass;
	logic [sirs_pkg::CFG_BITS-1:0]  mreg;
	logic [sirs_pkg::DEN_BITS-1:0]  denom;
	logic [sirs_pkg::DIFF_BITS-1:0] mul_a;
	logic [W-1:0]                   mul_b;
	logic                           mul_neg;
	logic [sirs_pkg::PROD_BITS-1:0] prod;
	logic [sirs_pkg::ACC_BITS-1:0]  prod_ext, prod_sgn;
	logic [sirs_pkg::ACC_BITS-1:0]  acc_abs;
	logic                           div_start;
	logic [sirs_pkg::NUM_BITS-1:0]  div_num;
	logic [sirs_pkg::DEN_BITS-1:0]  div_den;
	logic                           div_done;
	logic [sirs_pkg::NUM_BITS-1:0]  quot;
	logic [sirs_pkg::ACC_BITS-1:0]  q_ext;
	logic [sirs_pkg::ACC_BITS-1:0]  lam_w, lam_hi, lam_c;
	logic [sirs_pkg::ACC_BITS-1:0]  v_sum;
	logic [W-1:0]                   lam_word;
	logic [sirs_pkg::IDX_BITS-1:0]  load_base;

	assign idx = cmd.idx;

	// operand selection
	always_comb begin
		jk   = j_q[idx];
		vk   = v_q[idx];
		mreg = cfg[sirs_pkg::cfg_sel(idx)];
		mass = (mreg == '0) ? sirs_pkg::DEN_BITS'(1)
		                    : sirs_pkg::DEN_BITS'(mreg);
		denom = (|dsum_q[sirs_pkg::DSUM_BITS-1:sirs_pkg::DEN_BITS]) ? '1
		      : dsum_q[sirs_pkg::DEN_BITS-1:0];
		case (cmd.op)
			sirs_pkg::OP_MUL_DOT: begin
				mul_a   = {1'b0, sirs_pkg::abs_w(jk)};
				mul_b   = sirs_pkg::abs_w(vk);
				mul_neg = jk[W-1] ^ vk[W-1];
			end
			sirs_pkg::OP_MUL_APP: begin
				mul_a   = sirs_pkg::abs_d(dfin_q);
				mul_b   = sirs_pkg::abs_w(jk);
				mul_neg = dfin_q[sirs_pkg::DIFF_BITS-1] ^ jk[W-1];
			end
			default: begin
				mul_a   = {1'b0, sirs_pkg::abs_w(jk)};
				mul_b   = sirs_pkg::abs_w(jk);
				mul_neg = 1'b0;
			end
		endcase
		prod     = sirs_pkg::PROD_BITS'(mul_a) * sirs_pkg::PROD_BITS'(mul_b);
		prod_ext = sirs_pkg::ACC_BITS'(prod_mag_q);
		prod_sgn = prod_neg_q ? (~prod_ext + 1'b1) : prod_ext;
		acc_abs  = acc_q[sirs_pkg::ACC_BITS-1] ? (~acc_q + 1'b1) : acc_q;
		q_ext    = sirs_pkg::ACC_BITS'(quot);
	end

	// divider requests
	always_comb begin
		div_start = 1'b0;
		div_num   = sirs_pkg::NUM_BITS'(prod_mag_q);
		div_den   = mass;
		case (cmd.op)
			sirs_pkg::OP_DIV_SQ, sirs_pkg::OP_DIV_APP: div_start = 1'b1;
			sirs_pkg::OP_DIV_DL: begin
				div_start = 1'b1;
				div_num   = acc_abs[sirs_pkg::NUM_BITS-1:0];
				div_den   = denom;
			end
			default: div_start = 1'b0;
		endcase
	end

	sirs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	// clamp: upper limit first, lower limit last
	always_comb begin
		lam_w    = {{(sirs_pkg::ACC_BITS-W){l0_q[W-1]}}, l0_q} + dl_q;
		lam_hi   = ($signed(lam_w) > $signed({{(sirs_pkg::ACC_BITS-W){hi_q[W-1]}}, hi_q}))
		         ? {{(sirs_pkg::ACC_BITS-W){hi_q[W-1]}}, hi_q} : lam_w;
		lam_c    = ($signed(lam_hi) < $signed({{(sirs_pkg::ACC_BITS-W){lo_q[W-1]}}, lo_q}))
		         ? {{(sirs_pkg::ACC_BITS-W){lo_q[W-1]}}, lo_q} : lam_hi;
		lam_word = lam_c[W-1:0];
		v_sum    = {{(sirs_pkg::ACC_BITS-W){vk[W-1]}}, vk}
		         + (prod_neg_q ? (~q_ext + 1'b1) : q_ext);
		load_base = in_user[1] ? sirs_pkg::IDX_BITS'(3) : '0;
	end

	// velocity state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < sirs_pkg::NUM_TERMS; k++) v_q[k] <= '0;
		end else begin
			if (cmd.op == sirs_pkg::OP_CAPTURE && in_user[0] == sirs_pkg::CMD_LOAD) begin
				for (int c = 0; c < 3; c++)
					v_q[load_base + sirs_pkg::IDX_BITS'(c)] <= in_data[c*W +: W];
			end else if (cmd.op == sirs_pkg::OP_VEL) begin
				v_q[idx] <= sirs_pkg::sat_w(v_sum);
			end
		end
	end

	// row working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			sirs_pkg::OP_CAPTURE: begin
				for (int k = 0; k < sirs_pkg::NUM_TERMS; k++) j_q[k] <= in_data[k*W +: W];
				lo_q   <= in_data[sirs_pkg::F_LOW*W +: W];
				hi_q   <= in_data[sirs_pkg::F_HIGH*W +: W];
				l0_q   <= in_data[sirs_pkg::F_IMP*W +: W];
				acc_q  <= {{(sirs_pkg::ACC_BITS-W-sirs_pkg::FRAC_BITS)
				            {in_data[sirs_pkg::F_BIAS*W+W-1]}},
				           in_data[sirs_pkg::F_BIAS*W +: W], {sirs_pkg::FRAC_BITS{1'b0}}};
				dsum_q <= '0;
				imp_q  <= '0;
				flag_q <= 1'b0;
			end
			sirs_pkg::OP_MUL_SQ, sirs_pkg::OP_MUL_DOT, sirs_pkg::OP_MUL_APP: begin
				prod_mag_q <= prod;
				prod_neg_q <= mul_neg;
			end
			sirs_pkg::OP_SUM_SQ: dsum_q <= dsum_q + sirs_pkg::DSUM_BITS'(quot);
			sirs_pkg::OP_ADD_DOT: acc_q <= acc_q + prod_sgn;
			sirs_pkg::OP_DL: begin
				if (denom == '0) begin
					dl_q   <= '0;
					flag_q <= 1'b1;
				end else begin
					dl_q <= acc_q[sirs_pkg::ACC_BITS-1] ? q_ext : (~q_ext + 1'b1);
				end
			end
			sirs_pkg::OP_CLAMP: begin
				imp_q  <= lam_word;
				dfin_q <= {lam_word[W-1], lam_word} - {l0_q[W-1], l0_q};
			end
			default: flag_q <= flag_q;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == sirs_pkg::OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == sirs_pkg::OP_OUT) begin
			out_word_q[0] <= imp_q;
			for (int k = 0; k < sirs_pkg::NUM_TERMS; k++) out_word_q[k+1] <= v_q[k];
			out_flag_q <= flag_q;
		end
	end

	always_comb begin
		for (int k = 0; k < 7; k++) out_data[k*W +: W] = out_word_q[k];
	end

	assign out_valid         = out_valid_q;
	assign out_user          = out_flag_q;
	assign status.div_done   = div_done;
	assign status.denom_zero = (denom == '0);
	assign status.out_free   = !out_valid_q || out_ready;
	assign status.in_solve   = (in_user[0] == sirs_pkg::CMD_SOLVE);

endmodule

// ===== rtl/sirs_ctrl.sv =====
module sirs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sirs_pkg::status_t status,
	output sirs_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SQ_MUL  = 4'd1;
	localparam logic [3:0] S_SQ_DIV  = 4'd2;
	localparam logic [3:0] S_SQ_WAIT = 4'd3;
	localparam logic [3:0] S_DOT_MUL = 4'd4;
	localparam logic [3:0] S_DOT_ADD = 4'd5;
	localparam logic [3:0] S_DL_CHK  = 4'd6;
	localparam logic [3:0] S_DL_WAIT = 4'd7;
	localparam logic [3:0] S_CLAMP   = 4'd8;
	localparam logic [3:0] S_AP_MUL  = 4'd9;
	localparam logic [3:0] S_AP_DIV  = 4'd10;
	localparam logic [3:0] S_AP_WAIT = 4'd11;
	localparam logic [3:0] S_OUT     = 4'd12;

	logic [3:0]                    state_q, state_d;
	logic [sirs_pkg::IDX_BITS-1:0] idx_q, idx_d;
	logic [3:0]                    op;

	// sequence the row: denominator terms, dot product, divide, clamp, apply
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		op      = sirs_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = sirs_pkg::OP_CAPTURE;
					idx_d   = '0;
					state_d = status.in_solve ? S_SQ_MUL : S_OUT;
				end
			end
			S_SQ_MUL: begin
				op      = sirs_pkg::OP_MUL_SQ;
				state_d = S_SQ_DIV;
			end
			S_SQ_DIV: begin
				op      = sirs_pkg::OP_DIV_SQ;
				state_d = S_SQ_WAIT;
			end
			S_SQ_WAIT: begin
				if (status.div_done) begin
					op = sirs_pkg::OP_SUM_SQ;
					if (idx_q == sirs_pkg::LAST_IDX) begin
						idx_d   = '0;
						state_d = S_DOT_MUL;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_SQ_MUL;
					end
				end
			end
			S_DOT_MUL: begin
				op      = sirs_pkg::OP_MUL_DOT;
				state_d = S_DOT_ADD;
			end
			S_DOT_ADD: begin
				op = sirs_pkg::OP_ADD_DOT;
				if (idx_q == sirs_pkg::LAST_IDX) begin
					idx_d   = '0;
					state_d = S_DL_CHK;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_DOT_MUL;
				end
			end
			S_DL_CHK: begin
				if (status.denom_zero) begin
					op      = sirs_pkg::OP_DL;
					state_d = S_CLAMP;
				end else begin
					op      = sirs_pkg::OP_DIV_DL;
					state_d = S_DL_WAIT;
				end
			end
			S_DL_WAIT: begin
				if (status.div_done) begin
					op      = sirs_pkg::OP_DL;
					state_d = S_CLAMP;
				end
			end
			S_CLAMP: begin
				op      = sirs_pkg::OP_CLAMP;
				idx_d   = '0;
				state_d = S_AP_MUL;
			end
			S_AP_MUL: begin
				op      = sirs_pkg::OP_MUL_APP;
				state_d = S_AP_DIV;
			end
			S_AP_DIV: begin
				op      = sirs_pkg::OP_DIV_APP;
				state_d = S_AP_WAIT;
			end
			S_AP_WAIT: begin
				if (status.div_done) begin
					op = sirs_pkg::OP_VEL;
					if (idx_q == sirs_pkg::LAST_IDX) begin
						idx_d   = '0;
						state_d = S_OUT;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_AP_MUL;
					end
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					op      = sirs_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.op   = op;
	assign cmd.idx  = idx_q;

endmodule
